>>> sv/n2a_pkg.sv
package n2a_pkg;

  // widths of the fields
  localparam int unsigned NUM_W   = 32;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned DIGIT_W = 4;

  // the digit chain is wide enough for ten decimal digits
  localparam int unsigned NUM_CELLS  = 10;
  localparam int unsigned HEX_DIGITS = 8;
  // the hex nibbles sit in the top cells of the chain
  localparam int unsigned HEX_BASE   = NUM_CELLS - HEX_DIGITS;

  // counter covers the conversion bit count and the digit count
  localparam int unsigned CNT_W = 5;

  // format selector codes
  localparam logic ACT_DEC = 1'b0;
  localparam logic ACT_HEX = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h37;  // 'A' minus ten

  typedef struct packed {
    logic             action;
    logic [NUM_W-1:0] number;
  } n2a_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } n2a_out_t;

  // per-cycle command shared by every cell of the chain
  typedef struct packed {
    logic load;    // take the parallel load value
    logic dabble;  // add-3 correction then shift one bit up
    logic shift;   // take the digit of the lower neighbor
  } n2a_cell_ctl_t;

  // one digit to its upper-case ascii code
  function automatic logic [CHAR_W-1:0] n2a_ascii(input logic [DIGIT_W-1:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, nib};
    if (nib < 4'd10) begin
      n2a_ascii = CHAR_ZERO + ext;
    end else begin
      n2a_ascii = CHAR_ALPHA + ext;
    end
  endfunction

endpackage

>>> sv/number_to_ascii_formatter_core.sv
// Renders a 32-bit unsigned number as ASCII text, most significant character first,
// with last set on the final character. action 0 gives decimal without leading zeros
// (zero gives a single '0'); action 1 gives "0x" and eight upper-case hex digits.
// The digits live in a row of ten 4-bit cells. A decimal item is converted by
// double dabble, one number bit per cycle through the row, and then the row
// shifts up one cell per cycle, unless the output side stalls, while the top cell
// is sent out; leading zeros are shifted away without output. A hex item has its
// nibbles loaded straight into the cells. The block takes one item at a
// time; in_stall_o is high while an item is in work.
module number_to_ascii_formatter_core
  import n2a_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  n2a_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output n2a_out_t out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PFX0,
    ST_PFX1,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic             hex_q;
  logic [NUM_W-1:0] bits_q;
  logic [CNT_W-1:0] cnt_q;
  logic             started_q;
  logic             out_valid_q;
  n2a_out_t         out_q;

  n2a_cell_ctl_t      cell_ctl;
  logic [DIGIT_W-1:0] digit [NUM_CELLS];
  logic               carry [NUM_CELLS];
  logic [DIGIT_W-1:0] top_digit;

  logic in_fire;
  logic out_free;
  logic skip_zero;
  logic emit_fire;
  logic out_load;

  assign in_fire   = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign top_digit = digit[NUM_CELLS-1];

  // leading zero of a decimal text: drop it without output
  assign skip_zero = (state_q == ST_EMIT) && !hex_q && !started_q &&
                     (top_digit == '0) && (cnt_q != CNT_W'(1));
  assign emit_fire = (state_q == ST_EMIT) && !skip_zero && out_free;

  // a new output item enters the output register this cycle
  assign out_load = (((state_q == ST_PFX0) || (state_q == ST_PFX1)) && out_free) ||
                    emit_fire;

  // command to the digit row
  always_comb begin
    cell_ctl.load   = in_fire;
    cell_ctl.dabble = (state_q == ST_CONV);
    cell_ctl.shift  = skip_zero || emit_fire;
  end

  // row of digit cells, cell zero at the bottom
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic [DIGIT_W-1:0] load_digit;
    logic               bit_in;
    logic [DIGIT_W-1:0] digit_in;

    if (k >= HEX_BASE) begin : g_hex
      assign load_digit = (in_i.action == ACT_HEX) ?
                          in_i.number[DIGIT_W*(k-HEX_BASE) +: DIGIT_W] : '0;
    end else begin : g_zero
      assign load_digit = '0;
    end

    if (k == 0) begin : g_bottom
      assign bit_in   = bits_q[NUM_W-1];
      assign digit_in = '0;
    end else begin : g_link
      assign bit_in   = carry[k-1];
      assign digit_in = digit[k-1];
    end

    n2a_digit_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl),
      .load_digit_i (load_digit),
      .bit_i        (bit_in),
      .digit_i      (digit_in),
      .digit_o      (digit[k]),
      .carry_o      (carry[k])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hex_q       <= 1'b0;
      bits_q      <= '0;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            hex_q     <= (in_i.action == ACT_HEX);
            started_q <= 1'b0;
            bits_q    <= in_i.number;
            if (in_i.action == ACT_HEX) begin
              cnt_q   <= CNT_W'(HEX_DIGITS);
              state_q <= ST_PFX0;
            end else begin
              cnt_q   <= CNT_W'(NUM_W - 1);
              state_q <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          bits_q <= {bits_q[NUM_W-2:0], 1'b0};
          if (cnt_q == '0) begin
            cnt_q   <= CNT_W'(NUM_CELLS);
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        ST_PFX0: begin
          if (out_free) begin
            out_q.character <= CHAR_ZERO;
            out_q.last      <= 1'b0;
            state_q         <= ST_PFX1;
          end
        end
        ST_PFX1: begin
          if (out_free) begin
            out_q.character <= CHAR_X;
            out_q.last      <= 1'b0;
            state_q         <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip_zero) begin
            cnt_q <= cnt_q - CNT_W'(1);
          end else if (emit_fire) begin
            out_q.character <= n2a_ascii(top_digit);
            out_q.last      <= (cnt_q == CNT_W'(1));
            started_q       <= 1'b1;
            cnt_q           <= cnt_q - CNT_W'(1);
            if (cnt_q == CNT_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  // a decimal item starts a full-length conversion
  a_dec_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.action == ACT_DEC) |=>
      (state_q == ST_CONV) && (cnt_q == CNT_W'(NUM_W - 1)))
    else $error("decimal item did not start conversion");

  // remaining digit count stays within the row while emitting
  a_emit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q != '0) && (cnt_q <= CNT_W'(NUM_CELLS)))
    else $error("digit count out of range");

  // after conversion the decimal row holds valid bcd digits
  a_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && !hex_q |-> (top_digit <= 4'd9))
    else $error("non-bcd digit in decimal text");

  // the first decimal character is nonzero unless it is the only one
  a_no_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && !hex_q && !started_q |-> (top_digit != '0) || (cnt_q == CNT_W'(1)))
    else $error("leading zero sent");
`endif

endmodule

>>> sv/n2a_digit_cell.sv
module n2a_digit_cell
  import n2a_pkg::*;
(
  input  logic               clk_i,
  input  n2a_cell_ctl_t      ctl_i,
  input  logic [DIGIT_W-1:0] load_digit_i,
  input  logic               bit_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [DIGIT_W-1:0] digit_o,
  output logic               carry_o
);

  logic [DIGIT_W-1:0] digit_q;
  logic [DIGIT_W-1:0] digit_d;
  logic [DIGIT_W-1:0] adj;

  // add-3 correction of one bcd digit before it doubles
  assign adj = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;

  // next digit value
  always_comb begin
    digit_d = digit_q;
    if (ctl_i.load) begin
      digit_d = load_digit_i;
    end else if (ctl_i.dabble) begin
      digit_d = {adj[DIGIT_W-2:0], bit_i};
    end else if (ctl_i.shift) begin
      digit_d = digit_i;
    end
  end

  // digit storage
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;
  assign carry_o = adj[DIGIT_W-1];

endmodule

>>> verif/tb_number_to_ascii_formatter_core.sv
`timescale 1ns / 1ps

module tb_number_to_ascii_formatter_core;
  import n2a_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 208;
  localparam int unsigned CALM_ITEMS   = 40;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned DIR_ROWS     = 22;

  localparam logic [79:0]       NO_TEXT  = '0;
  localparam logic [CHAR_W-1:0] ASC_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASC_UP_A = 7'h41;
  localparam logic [CHAR_W-1:0] ASC_X    = 7'h78;

  // one directed item, with its text typed in or left empty for the predictor
  typedef struct packed {
    logic             action;
    logic [NUM_W-1:0] number;
    logic [79:0]      text;
  } text_row_t;

  logic     clk_i    = 1'b0;
  logic     rst_ni   = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  n2a_in_t  in_item  = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  n2a_out_t out_item;

  n2a_out_t    pending_chars[$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  logic        calm         = 1'b0;

  text_row_t directed_rows [DIR_ROWS] = '{
    '{ACT_DEC, 32'd0,          "0"},
    '{ACT_DEC, 32'd1,          "1"},
    '{ACT_DEC, 32'd9,          "9"},
    '{ACT_DEC, 32'd10,         "10"},
    '{ACT_DEC, 32'd99,         "99"},
    '{ACT_DEC, 32'd100,        "100"},
    '{ACT_DEC, 32'd999999999,  "999999999"},
    '{ACT_DEC, 32'd1000000000, "1000000000"},
    '{ACT_DEC, 32'hFFFF_FFFF,  "4294967295"},
    '{ACT_DEC, 32'hFFFF_FFFE,  NO_TEXT},
    '{ACT_DEC, 32'h8000_0000,  NO_TEXT},
    '{ACT_DEC, 32'h5555_5555,  NO_TEXT},
    '{ACT_DEC, 32'hAAAA_AAAA,  NO_TEXT},
    '{ACT_DEC, 32'd1234567890, "1234567890"},
    '{ACT_HEX, 32'h0000_0000,  "0x00000000"},
    '{ACT_HEX, 32'hFFFF_FFFF,  "0xFFFFFFFF"},
    '{ACT_HEX, 32'h0123_4567,  "0x01234567"},
    '{ACT_HEX, 32'h89AB_CDEF,  "0x89ABCDEF"},
    '{ACT_HEX, 32'h0000_000A,  NO_TEXT},
    '{ACT_HEX, 32'h8000_0001,  NO_TEXT},
    '{ACT_HEX, 32'h5555_5555,  NO_TEXT},
    '{ACT_HEX, 32'hAAAA_AAAA,  NO_TEXT}
  };

  number_to_ascii_formatter_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item)
  );

  always #1 clk_i = ~clk_i;

  // queue the characters of a typed-in text, leading zero bytes skipped
  function automatic void expect_text(input logic [79:0] text);
    n2a_out_t ch;
    int       n;
    int       k;
    n = 0;
    k = 0;
    for (int i = 0; i < 10; i++) begin
      if (text[i*8 +: 8] != 8'h00) n++;
    end
    for (int i = 9; i >= 0; i--) begin
      if (text[i*8 +: 8] != 8'h00) begin
        k++;
        ch.character = text[i*8 +: CHAR_W];
        ch.last      = (k == n);
        pending_chars.push_back(ch);
      end
    end
  endfunction

  // predict the characters of one number, most significant first
  function automatic void render_number(input n2a_in_t item);
    logic [DIGIT_W-1:0] digits [10];
    logic [DIGIT_W-1:0] nib;
    logic [NUM_W-1:0]   rest;
    n2a_out_t           ch;
    int                 n;
    if (item.action == ACT_HEX) begin
      ch.last      = 1'b0;
      ch.character = ASC_ZERO;
      pending_chars.push_back(ch);
      ch.character = ASC_X;
      pending_chars.push_back(ch);
      for (int k = 7; k >= 0; k--) begin
        nib = item.number[k*4 +: 4];
        if (nib < 4'd10) begin
          ch.character = ASC_ZERO + {3'b000, nib};
        end else begin
          ch.character = ASC_UP_A + {3'b000, nib} - 7'd10;
        end
        ch.last = (k == 0);
        pending_chars.push_back(ch);
      end
    end else begin
      // digits come out least significant first, zero still gives one digit
      rest = item.number;
      n    = 0;
      do begin
        digits[n] = DIGIT_W'(rest % 10);
        rest      = rest / 10;
        n++;
      end while (rest != 0);
      for (int k = n - 1; k >= 0; k--) begin
        ch.character = ASC_ZERO + {3'b000, digits[k]};
        ch.last      = (k == 0);
        pending_chars.push_back(ch);
      end
    end
  endfunction

  // offer one number, sometimes with a random gap ahead of it, and hold it until taken
  task automatic send_number(input n2a_in_t item, input logic [79:0] text);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (text == NO_TEXT) begin
      render_number(item);
    end else begin
      expect_text(text);
    end
  endtask

  // hold the sender back until every queued character has come out
  task automatic wait_for_empty();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // output stall in random bursts, none in the calm tail
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted character and watch for a hang
  always @(posedge clk_i) begin
    n2a_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected item: character %h last %b", out_item.character, out_item.last);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_item.character != want.character) begin
          $error("character: expected %h, got %h", want.character, out_item.character);
          fail_count++;
        end
        if (out_item.last != want.last) begin
          $error("last: expected %b, got %b", want.last, out_item.last);
          fail_count++;
        end
      end
    end
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    n2a_in_t          item;
    int unsigned      width;
    logic [NUM_W-1:0] power;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      item.action = directed_rows[r].action;
      item.number = directed_rows[r].number;
      send_number(item, directed_rows[r].text);
    end
    wait_for_empty();

    // random numbers, mostly of random magnitude, some around powers of ten, some at the extremes
    for (int r = 0; r < RANDOM_ITEMS; r++) begin
      calm <= (r >= RANDOM_ITEMS - CALM_ITEMS);
      if (r == RANDOM_ITEMS / 2) wait_for_empty();
      item.action = $urandom_range(0, 1) ? ACT_HEX : ACT_DEC;
      case ($urandom_range(0, 7))
        0: begin
          power = 1;
          repeat ($urandom_range(0, 9)) power = power * 10;
          item.number = power - $urandom_range(0, 1);
        end
        1: item.number = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        default: begin
          width       = $urandom_range(1, 32);
          item.number = $urandom;
          if (width < 32) item.number = item.number & ((32'd1 << width) - 1);
        end
      endcase
      send_number(item, NO_TEXT);
    end
    in_valid <= 1'b0;

    // let the block finish and make sure nothing extra comes out
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
